// ===== hw/rtl/tmw_pkg.sv =====
// Shared types, codes and helper functions of the maze walker.
package tmw_pkg;

  // Default maze memory dimensions.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_STEP    = 2'd2;

  // Move directions; DIR_NONE means no move yet.
  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_SEARCH = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_STUCK  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_START_X     = 3'd2;
  localparam logic [2:0] CFG_START_Y     = 3'd3;
  localparam logic [2:0] CFG_END_X       = 3'd4;
  localparam logic [2:0] CFG_END_Y       = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       is_wall;
  } req_item_t;

  typedef struct packed {
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [2:0] arrival_dir;
    logic       moved;
    logic [1:0] status;
  } rsp_item_t;

  // Direction pointing the opposite way.
  function automatic logic [1:0] dir_back(input logic [1:0] d);
    return d ^ 2'b10;
  endfunction

  // Add one mark to the passage in direction d, saturating at two.
  function automatic logic [7:0] mark_add(input logic [7:0] marks, input logic [1:0] d);
    logic [7:0] res;
    logic [1:0] m;
    res = marks;
    m = marks[{d, 1'b0} +: 2];
    if (m < 2'd2) begin
      m = m + 2'd1;
    end
    res[{d, 1'b0} +: 2] = m;
    return res;
  endfunction

endpackage

// ===== hw/rtl/tmw_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module tmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tremaux_maze_walker_top.sv =====
// Top level of the Tremaux maze walker: control sequencer around the wall and mark memories.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_item (kind, cell_x, cell_y, is_wall)
//   rsp       out        rsp_valid/rsp_ready  rsp_item (pos_x, pos_y, arrival_dir, moved, status)
//   cfg       in         cfg_we               cfg_index, cfg_wdata (no wait, no read-back)
//
// A write item writes its wall bit in the accepting cycle when the cell lies inside the
// memory, then moves to the post state, which loads its result into the output register
// once that register is free. A step that moves runs through the accepting cycle, the scan
// (the four neighbour wall bits are read one per cycle through the single read port, whose
// read data is registered), a decide state that writes the current cell, a target state that
// updates the target cell's marks, and the post state. A step with no exit skips the target
// state; a step on the goal, outside the grid or after done goes straight to the post state.
// A restart item sweeps the mark memory, one cell per cycle, then posts its result.
// After reset the same sweep runs with req_ready low; configuration writes are taken at all times.
// One item is worked on at a time; a result waiting in the output register does not stop
// the next item from being accepted, only from being posted.
module tremaux_maze_walker_top #(
  parameter int MAX_WIDTH  = tmw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tmw_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  tmw_pkg::req_item_t req_item,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tmw_pkg::rsp_item_t rsp_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_wdata
);

  import tmw_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int LIM_W = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int LIM_H = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_DECIDE,
    S_TGT,
    S_POST
  } state_t;

  // Linear cell address; writes use it only with coordinates inside the memory.
  function automatic logic [AW-1:0] cell_addr(input logic [5:0] x, input logic [5:0] y);
    return AW'(32'(y) * MAX_WIDTH + 32'(x));
  endfunction

  state_t      state;
  logic [2:0]  cnt;
  logic [AW-1:0] clr_addr;
  logic        clr_post;

  // Configuration registers.
  logic [6:0]  grid_width;
  logic [6:0]  grid_height;
  logic [5:0]  start_x;
  logic [5:0]  start_y;
  logic [5:0]  end_x;
  logic [5:0]  end_y;

  // Walker state.
  logic [5:0]  walker_x;
  logic [5:0]  walker_y;
  logic [2:0]  last_dir;
  logic        done_flag;

  // Step working registers.
  logic [3:0]  walls;
  logic [8:0]  here_word;
  logic [1:0]  dir_sel;
  logic [5:0]  tgt_x;
  logic [5:0]  tgt_y;
  logic [AW-1:0] tgt_addr;
  logic        res_moved;
  logic [1:0]  res_status;

  // Memory ports.
  logic          wall_we;
  logic [AW-1:0] wall_waddr;
  logic          wall_re;
  logic [AW-1:0] wall_raddr;
  logic [0:0]    wall_rdata;
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  logic [8:0]    mark_wdata;
  logic          mark_re;
  logic [AW-1:0] mark_raddr;
  logic [8:0]    mark_rdata;

  // Derived combinational values.
  logic [6:0]  w_used;
  logic [6:0]  h_used;
  logic [AW-1:0] here_addr;
  logic [5:0]  nbr_x [4];
  logic [5:0]  nbr_y [4];
  logic [3:0]  ingrid;
  logic [3:0]  open_dir;
  logic [1:0]  first_free;
  logic        free_ok;
  logic [1:0]  first_once;
  logic        once_ok;
  logic        back_ok;
  logic [1:0]  back_dir;
  logic [1:0]  choice;
  logic        choice_ok;
  logic        go_ok;
  logic        out_free;
  logic        req_fire;
  logic        in_mem;

  // Grid size in use, saturated into its legal range.
  always_comb begin
    if (grid_width == 7'd0) begin
      w_used = 7'd1;
    end else if (grid_width > 7'(LIM_W)) begin
      w_used = 7'(LIM_W);
    end else begin
      w_used = grid_width;
    end
    if (grid_height == 7'd0) begin
      h_used = 7'd1;
    end else if (grid_height > 7'(LIM_H)) begin
      h_used = 7'(LIM_H);
    end else begin
      h_used = grid_height;
    end
  end

  assign here_addr = cell_addr(walker_x, walker_y);
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign in_mem    = (32'(req_item.cell_x) < MAX_WIDTH) && (32'(req_item.cell_y) < MAX_HEIGHT);

  // Neighbour coordinates in the order up, right, down, left.
  always_comb begin
    nbr_x[0] = walker_x;
    nbr_y[0] = walker_y - 6'd1;
    nbr_x[1] = walker_x + 6'd1;
    nbr_y[1] = walker_y;
    nbr_x[2] = walker_x;
    nbr_y[2] = walker_y + 6'd1;
    nbr_x[3] = walker_x - 6'd1;
    nbr_y[3] = walker_y;
    ingrid[0] = (walker_y != 6'd0);
    ingrid[1] = ({1'b0, walker_x} + 7'd1) < w_used;
    ingrid[2] = ({1'b0, walker_y} + 7'd1) < h_used;
    ingrid[3] = (walker_x != 6'd0);
  end

  // Tremaux choice from the scanned walls and the current cell's marks.
  always_comb begin
    open_dir   = ingrid & ~walls;
    first_free = 2'd0;
    free_ok    = 1'b0;
    first_once = 2'd0;
    once_ok    = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (open_dir[i] && here_word[2*i +: 2] == 2'd0) begin
        first_free = 2'(i);
        free_ok    = 1'b1;
      end
      if (open_dir[i] && here_word[2*i +: 2] == 2'd1) begin
        first_once = 2'(i);
        once_ok    = 1'b1;
      end
    end
    back_ok  = (last_dir != DIR_NONE);
    back_dir = dir_back(last_dir[1:0]);
    choice    = 2'd0;
    choice_ok = 1'b0;
    if (!here_word[8]) begin
      if (free_ok) begin
        choice    = first_free;
        choice_ok = 1'b1;
      end else if (back_ok) begin
        choice    = back_dir;
        choice_ok = 1'b1;
      end
    end else begin
      if (back_ok && here_word[{back_dir, 1'b0} +: 2] == 2'd1) begin
        choice    = back_dir;
        choice_ok = 1'b1;
      end else if (free_ok) begin
        choice    = first_free;
        choice_ok = 1'b1;
      end else if (once_ok) begin
        choice    = first_once;
        choice_ok = 1'b1;
      end
    end
    // A turn back out of the grid in use is not taken.
    go_ok = choice_ok && ingrid[choice];
  end

  // Memory port control.
  always_comb begin
    wall_we    = (state == S_IDLE) && req_fire && (req_item.kind == KIND_WRITE) && in_mem;
    wall_waddr = cell_addr(req_item.cell_x, req_item.cell_y);
    wall_re    = (state == S_SCAN) && !cnt[2];
    wall_raddr = ingrid[cnt[1:0]] ? cell_addr(nbr_x[cnt[1:0]], nbr_y[cnt[1:0]]) : here_addr;

    mark_we    = 1'b0;
    mark_waddr = here_addr;
    mark_wdata = '0;
    mark_re    = 1'b0;
    mark_raddr = here_addr;
    case (state)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_addr;
      end
      S_SCAN: begin
        mark_re = (cnt == 3'd0);
      end
      S_DECIDE: begin
        // The current cell becomes seen whether or not the walker moves.
        mark_we    = 1'b1;
        mark_wdata = {1'b1, go_ok ? mark_add(here_word[7:0], choice) : here_word[7:0]};
        mark_re    = go_ok;
        mark_raddr = cell_addr(nbr_x[choice], nbr_y[choice]);
      end
      S_TGT: begin
        mark_we    = 1'b1;
        mark_waddr = tgt_addr;
        mark_wdata = {mark_rdata[8], mark_add(mark_rdata[7:0], dir_back(dir_sel))};
      end
      default: begin
      end
    endcase
  end

  tmw_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_wall_ram (
    .clk  (clk),
    .we   (wall_we),
    .waddr(wall_waddr),
    .wdata(req_item.is_wall),
    .re   (wall_re),
    .raddr(wall_raddr),
    .rdata(wall_rdata)
  );

  // Seen bit in the top position, then two mark bits per direction.
  tmw_ram #(
    .WIDTH(9),
    .DEPTH(CELLS)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_waddr),
    .wdata(mark_wdata),
    .re   (mark_re),
    .raddr(mark_raddr),
    .rdata(mark_rdata)
  );

  // Configuration registers take a write in any cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      start_x     <= 6'd0;
      start_y     <= 6'd0;
      end_x       <= 6'd63;
      end_y       <= 6'd63;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height <= cfg_wdata;
        CFG_START_X:     start_x     <= cfg_wdata[5:0];
        CFG_START_Y:     start_y     <= cfg_wdata[5:0];
        CFG_END_X:       end_x       <= cfg_wdata[5:0];
        CFG_END_Y:       end_y       <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, walker state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= 3'd0;
      clr_addr  <= '0;
      clr_post  <= 1'b0;
      walker_x  <= 6'd0;
      walker_y  <= 6'd0;
      last_dir  <= DIR_NONE;
      done_flag <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // The output register loads a posted result and empties once it is taken.
      if (state == S_POST && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            res_moved <= 1'b0;
            case (req_item.kind)
              KIND_RESTART: begin
                walker_x   <= start_x;
                walker_y   <= start_y;
                last_dir   <= DIR_NONE;
                done_flag  <= 1'b0;
                res_status <= ST_SEARCH;
                clr_addr   <= '0;
                clr_post   <= 1'b1;
                state      <= S_CLEAR;
              end
              KIND_STEP: begin
                if (done_flag) begin
                  res_status <= ST_DONE;
                  state      <= S_POST;
                end else if (walker_x == end_x && walker_y == end_y) begin
                  done_flag  <= 1'b1;
                  res_status <= ST_DONE;
                  state      <= S_POST;
                end else if ({1'b0, walker_x} >= w_used || {1'b0, walker_y} >= h_used) begin
                  res_status <= ST_STUCK;
                  state      <= S_POST;
                end else begin
                  cnt   <= 3'd0;
                  state <= S_SCAN;
                end
              end
              default: begin
                res_status <= done_flag ? ST_DONE : ST_SEARCH;
                state      <= S_POST;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= clr_post ? S_POST : S_IDLE;
          end
        end
        S_SCAN: begin
          // Read data is registered and arrives in the cycle after its address.
          if (cnt != 3'd0) begin
            walls[cnt[1:0] - 2'd1] <= wall_rdata[0];
          end
          if (cnt == 3'd1) begin
            here_word <= mark_rdata;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          dir_sel  <= choice;
          tgt_x    <= nbr_x[choice];
          tgt_y    <= nbr_y[choice];
          tgt_addr <= cell_addr(nbr_x[choice], nbr_y[choice]);
          if (go_ok) begin
            state <= S_TGT;
          end else begin
            res_moved  <= 1'b0;
            res_status <= ST_STUCK;
            state      <= S_POST;
          end
        end
        S_TGT: begin
          walker_x  <= tgt_x;
          walker_y  <= tgt_y;
          last_dir  <= {1'b0, dir_sel};
          res_moved <= 1'b1;
          if (tgt_x == end_x && tgt_y == end_y) begin
            done_flag  <= 1'b1;
            res_status <= ST_DONE;
          end else begin
            res_status <= ST_SEARCH;
          end
          state <= S_POST;
        end
        S_POST: begin
          if (out_free) begin
            rsp_item  <= '{pos_x: walker_x, pos_y: walker_y, arrival_dir: last_dir,
                           moved: res_moved, status: res_status};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result that reports a move never reports the walker stuck.
  a_moved_not_stuck: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.moved |-> rsp_item.status != ST_STUCK)
    else $error("moved result reports stuck");

  // A result without any move direction cannot report a move.
  a_none_not_moved: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.arrival_dir == DIR_NONE |-> !rsp_item.moved)
    else $error("move reported without a direction");

  // The neighbour scan only runs with the walker inside the grid in use.
  a_scan_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> {1'b0, walker_x} < w_used && {1'b0, walker_y} < h_used)
    else $error("neighbour scan outside the grid");

  // The target update never hits the cell written in the decide state just before it.
  a_tgt_differs: assert property (@(posedge clk) disable iff (rst)
    state == S_TGT |-> tgt_addr != here_addr)
    else $error("target cell equals current cell");

  // The decide state is only entered from the last scan step, with the scan counter at four.
  a_scan_length: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> $past(state) == S_SCAN && $past(cnt) == 3'd4)
    else $error("decision without a full neighbour scan");

endmodule
